// ----- rtl/core/bitmap_page_allocator_defines.svh -----
// Assertion macros for the bitmap page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

`define BPA_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bitmap_page_allocator: assertion failed");

`define BPA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bitmap_page_allocator: assertion failed");

`else

`define BPA_ASSERT_IMPLY(label, clk, rst, pre, post)

`define BPA_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ----- rtl/core/bpa_pkg.sv -----
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

   localparam int NUM_PAGES_DEF = 65536;
   localparam int WORD_BITS     = 64;
   localparam int OFS_W         = 7;
   localparam int CMD_W         = 2;
   localparam int START_W       = 16;
   localparam int COUNT_W       = 17;
   localparam int LIMIT_W       = 17;
   localparam int STATUS_W      = 2;
   localparam int PAGE_W        = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_RUN    = 2'd1,
      STATUS_BAD_COUNT = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [OFS_W-1:0]     lo;
      logic [OFS_W-1:0]     hi;
   } unit_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] mask;
      logic [OFS_W-1:0]     used_pos;
      logic [OFS_W-1:0]     free_pos;
   } unit_rsp_type;

   typedef struct packed {
      status_type          status;
      logic [PAGE_W-1:0]   page;
   } result_type;

endpackage

// ----- rtl/core/bpa_map_ram.sv -----
// Page bitmap storage, one 64-bit word per address, registered read.
module bpa_map_ram #(
   parameter int WORDS = bpa_pkg::NUM_PAGES_DEF / bpa_pkg::WORD_BITS,
   parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [bpa_pkg::WORD_BITS-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [bpa_pkg::WORD_BITS-1:0]  rd_data
);

   logic [bpa_pkg::WORD_BITS-1:0] mem_ff [WORDS];
   logic [bpa_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bpa_word_unit.sv -----
// Shared word unit: range mask and first used / first free search in one map word.
module bpa_word_unit (
   input  bpa_pkg::unit_req_type unit_req,
   output bpa_pkg::unit_rsp_type unit_rsp
);

   localparam int WB = bpa_pkg::WORD_BITS;
   localparam int OW = bpa_pkg::OFS_W;

   logic [WB-1:0] ge_lo;
   logic [WB-1:0] lt_hi;
   logic [WB-1:0] eff_used;
   logic [WB-1:0] used_ge;
   logic [WB-1:0] ge_u1;
   logic [WB-1:0] free_ge;
   logic [OW-1:0] used_pos;
   logic [OW-1:0] free_pos;
   logic [OW-1:0] u1;

   always_comb begin
      for (int i = 0; i < WB; i++) begin
         ge_lo[i] = (OW'(i) >= unit_req.lo);
         lt_hi[i] = (OW'(i) < unit_req.hi);
      end
      // Pages at or above the upper bound count as used.
      eff_used = unit_req.word | ~lt_hi;
      used_ge  = eff_used & ge_lo;
      used_pos = OW'(WB);
      for (int i = WB - 1; i >= 0; i--) begin
         if (used_ge[i]) begin
            used_pos = OW'(i);
         end
      end
      u1 = used_pos + OW'(1);
      for (int i = 0; i < WB; i++) begin
         ge_u1[i] = (OW'(i) >= u1);
      end
      free_ge  = ~eff_used & ge_u1;
      free_pos = OW'(WB);
      for (int i = WB - 1; i >= 0; i--) begin
         if (free_ge[i]) begin
            free_pos = OW'(i);
         end
      end
   end

   assign unit_rsp.mask     = ge_lo & lt_hi;
   assign unit_rsp.used_pos = used_pos;
   assign unit_rsp.free_pos = free_pos;

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
// Sequencer: clearing pass, first-fit scan and read-modify-write of bitmap runs.
`include "bitmap_page_allocator_defines.svh"

module bpa_ctrl #(
   parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bpa_pkg::CMD_W-1:0]      req_cmd,
   input  logic [bpa_pkg::START_W-1:0]    req_start,
   input  logic [bpa_pkg::COUNT_W-1:0]    req_count,
   input  logic [bpa_pkg::LIMIT_W-1:0]    limit,
   input  logic                           rsp_free,
   output logic                           rsp_load,
   output bpa_pkg::result_type            result
);

   localparam int WB    = bpa_pkg::WORD_BITS;
   localparam int OW    = bpa_pkg::OFS_W;
   localparam int WORDS = (NUM_PAGES + WB - 1) / WB;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int NPW   = $clog2(NUM_PAGES + 1);
   localparam int PW    = (NPW > bpa_pkg::COUNT_W) ? NPW : bpa_pkg::COUNT_W;
   localparam logic [PW-1:0] NP_X = PW'(NUM_PAGES);

   typedef enum logic [6:0] {
      ST_CLEAR     = 7'b0000001,
      ST_IDLE      = 7'b0000010,
      ST_SCAN_RD   = 7'b0000100,
      ST_SCAN_EVAL = 7'b0001000,
      ST_WR_RD     = 7'b0010000,
      ST_WR_MOD    = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [PW-1:0]           cur_ff, cur_in;
   logic [OW-1:0]           ofs_ff, ofs_in;
   logic [PW-1:0]           run_ff, run_in;
   logic [PW-1:0]           end_ff, end_in;
   logic [PW-1:0]           count_ff, count_in;
   logic                    used_ff, used_in;
   bpa_pkg::status_type     status_ff, status_in;
   logic [bpa_pkg::PAGE_W-1:0] page_ff, page_in;

   bpa_pkg::unit_req_type   unit_req;
   bpa_pkg::unit_rsp_type   unit_rsp;
   logic [WB-1:0]           rd_data;
   logic [WB-1:0]           wr_data;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic                    rd_en;

   logic [PW-1:0]           count_x;
   logic [PW-1:0]           start_x;
   logic [PW-1:0]           lim_x;
   logic [PW:0]             wr_sum;
   logic [PW-1:0]           wr_end;
   logic [PW-1:0]           seg_len;
   logic [PW-1:0]           run_sum;
   logic [PW-1:0]           hit_start;
   logic [PW:0]             next_base;
   logic                    last_word;
   logic                    same_word;

   assign count_x   = PW'(req_count);
   assign start_x   = PW'(req_start);
   assign lim_x     = (PW'(limit) > NP_X) ? NP_X : PW'(limit);
   assign wr_sum    = (PW+1)'(req_start) + (PW+1)'(req_count);
   assign wr_end    = (wr_sum > (PW+1)'(NUM_PAGES)) ? NP_X : PW'(wr_sum);

   assign same_word = (cur_ff[PW-1:6] == end_ff[PW-1:6]);
   assign unit_req.word = rd_data;
   assign unit_req.lo   = ofs_ff;
   assign unit_req.hi   = same_word ? {1'b0, end_ff[5:0]} : OW'(WB);

   assign seg_len   = PW'(unit_rsp.used_pos - ofs_ff);
   assign run_sum   = run_ff + seg_len;
   assign hit_start = cur_ff + PW'(ofs_ff) - run_ff;
   assign next_base = {1'b0, cur_ff} + (PW+1)'(WB);
   assign last_word = (next_base >= {1'b0, end_ff});

   assign rd_en   = (state_ff == ST_SCAN_RD) || (state_ff == ST_WR_RD);
   assign wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_WR_MOD);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : cur_ff[AW+5:6];
   assign wr_data = (state_ff == ST_CLEAR) ? '1 :
                    (used_ff ? (rd_data | unit_rsp.mask) : (rd_data & ~unit_rsp.mask));

   bpa_map_ram #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cur_ff[AW+5:6]),
      .rd_data (rd_data)
   );

   bpa_word_unit u_word_unit (
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      ofs_in    = ofs_ff;
      run_in    = run_ff;
      end_in    = end_ff;
      count_in  = count_ff;
      used_in   = used_ff;
      status_in = status_ff;
      page_in   = page_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               status_in = bpa_pkg::STATUS_OK;
               page_in   = '0;
               count_in  = count_x;
               case (req_cmd)
                  bpa_pkg::CMD_ALLOC: begin
                     cur_in  = '0;
                     ofs_in  = '0;
                     run_in  = '0;
                     end_in  = lim_x;
                     used_in = 1'b1;
                     if ((count_x == '0) || (count_x > NP_X)) begin
                        status_in = bpa_pkg::STATUS_BAD_COUNT;
                        state_in  = ST_DONE;
                     end else if (lim_x == '0) begin
                        status_in = bpa_pkg::STATUS_NO_RUN;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  bpa_pkg::CMD_FREE, bpa_pkg::CMD_RESERVE: begin
                     used_in = (req_cmd == bpa_pkg::CMD_RESERVE);
                     end_in  = wr_end;
                     cur_in  = {start_x[PW-1:6], 6'd0};
                     ofs_in  = {1'b0, start_x[5:0]};
                     if (start_x >= wr_end) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_WR_RD;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            if (run_sum >= count_ff) begin
               // The free span ending here completes the run, so mark it used.
               page_in  = hit_start[bpa_pkg::PAGE_W-1:0];
               end_in   = hit_start + count_ff;
               cur_in   = {hit_start[PW-1:6], 6'd0};
               ofs_in   = {1'b0, hit_start[5:0]};
               state_in = ST_WR_RD;
            end else if ((unit_rsp.used_pos == OW'(WB)) || (unit_rsp.free_pos == OW'(WB))) begin
               run_in = (unit_rsp.used_pos == OW'(WB)) ? run_sum : '0;
               cur_in = PW'(next_base);
               ofs_in = '0;
               if (last_word) begin
                  status_in = bpa_pkg::STATUS_NO_RUN;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end else begin
               // Used pages break the run; resume at the next free page of this word.
               run_in = '0;
               ofs_in = unit_rsp.free_pos;
            end
         end
         ST_WR_RD: begin
            state_in = ST_WR_MOD;
         end
         ST_WR_MOD: begin
            cur_in = PW'(next_base);
            ofs_in = '0;
            if (last_word) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WR_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      ofs_ff    <= ofs_in;
      run_ff    <= run_in;
      end_ff    <= end_in;
      count_ff  <= count_in;
      used_ff   <= used_in;
      status_ff <= status_in;
      page_ff   <= page_in;
   end

   assign result.status = status_ff;
   assign result.page   = page_ff;

   `BPA_ASSERT_IMPLY(a_scan_in_range, clock, reset, state_ff == ST_SCAN_RD, cur_ff < end_ff)
   `BPA_ASSERT_IMPLY(a_write_in_range, clock, reset, state_ff == ST_WR_MOD, cur_ff < end_ff)
   `BPA_ASSERT_IMPLY(a_ofs_in_word, clock, reset, (state_ff == ST_SCAN_EVAL) || (state_ff == ST_WR_MOD), ofs_ff < OW'(WB))
   `BPA_ASSERT_IMPLY(a_run_fits, clock, reset, state_ff == ST_SCAN_EVAL, (PW+1)'(run_ff) <= ((PW+1)'(cur_ff) + (PW+1)'(ofs_ff)))
   `BPA_ASSERT_NEXT(a_load_to_idle, clock, reset, rsp_load, state_ff == ST_IDLE)

endmodule

// ----- rtl/core/bitmap_page_allocator.sv -----
// Top level of the bitmap first-fit page allocator.
//
//   channel   direction  tdata                          tuser
//   req_      in         [15:0] start_page,             [1:0] cmd
//                        [32:16] run_length
//   rsp_      out        [15:0] page                    [1:0] status
//   csr_      in         csr_wdata = search_limit       -
//
// After reset a clearing pass writes the map to all used, one 64-bit word a cycle;
// no request is taken meanwhile. Allocate reads each map word it scans and
// evaluates a mixed word once more per further free stretch, then reads and writes
// each word it marks used; free and reserve read and write each word touched.
// A finished result waits in the output register while the next request is taken.
module bitmap_page_allocator #(
   parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [39:0]                      req_tdata,  // start_page, run_length
   input  logic [bpa_pkg::CMD_W-1:0]        req_tuser,  // cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bpa_pkg::PAGE_W-1:0]       rsp_tdata,  // page
   output logic [bpa_pkg::STATUS_W-1:0]     rsp_tuser,  // status
   input  logic                             csr_wen,
   input  logic [bpa_pkg::LIMIT_W-1:0]      csr_wdata
);

   logic [bpa_pkg::LIMIT_W-1:0]  limit_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::PAGE_W-1:0]   rsp_page_ff;
   logic [bpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                         rsp_free;
   logic                         rsp_load;
   bpa_pkg::result_type          result;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   bpa_ctrl #(
      .NUM_PAGES (NUM_PAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_start (req_tdata[15:0]),
      .req_count (req_tdata[32:16]),
      .limit     (limit_ff),
      .rsp_free  (rsp_free),
      .rsp_load  (rsp_load),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= bpa_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_page_ff   <= result.page;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_page_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the bitmap first-fit page allocator.
module tb_top;

   localparam int MAP_PAGES      = bpa_pkg::NUM_PAGES_DEF;
   localparam int MAP_WORDS      = MAP_PAGES / bpa_pkg::WORD_BITS;
   localparam int WB             = bpa_pkg::WORD_BITS;
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int MAX_REPORTS    = 10;
   localparam logic [bpa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      bpa_pkg::status_type        status;
      logic [bpa_pkg::PAGE_W-1:0] page;
   } page_reply_type;

   typedef struct {
      int first;
      int count;
   } page_run_type;

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [39:0]                  req_tdata  = '0;  // [15:0] start_page, [32:16] run_length
   logic [bpa_pkg::CMD_W-1:0]    req_tuser  = '0;  // [1:0] cmd
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [bpa_pkg::PAGE_W-1:0]   rsp_tdata;        // [15:0] page
   logic [bpa_pkg::STATUS_W-1:0] rsp_tuser;        // [1:0] status
   logic                         csr_wen    = 1'b0;
   logic [bpa_pkg::LIMIT_W-1:0]  csr_wdata  = '0;

   // Local copy of the page map (1 = used) and of the search limit.
   logic [WB-1:0]               page_words [MAP_WORDS];
   logic [bpa_pkg::LIMIT_W-1:0] limit_setting = bpa_pkg::LIMIT_RESET;

   page_reply_type replies_due [$];
   page_run_type   granted_runs [$];

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int items_sent      = 0;
   int grants_made     = 0;
   int replies_checked = 0;
   int mismatches      = 0;
   int limits_written  = 0;

   bitmap_page_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void mark_pages(input int first, input int count, input bit used);
      int last;
      last = first + count;
      if (last > MAP_PAGES) last = MAP_PAGES;
      for (int p = first; p < last; p++) page_words[p / WB][p % WB] = used;
   endfunction

   // Applies one request to the local map and returns the reply it must produce.
   function automatic page_reply_type apply_page_request(
         input logic [bpa_pkg::CMD_W-1:0]   cmd,
         input logic [bpa_pkg::START_W-1:0] first,
         input logic [bpa_pkg::COUNT_W-1:0] count);
      page_reply_type reply;
      int lim;
      int p;
      int run;
      int found;
      reply.status = bpa_pkg::STATUS_OK;
      reply.page   = '0;
      case (cmd)
         bpa_pkg::CMD_ALLOC: begin
            if (count == 0 || count > MAP_PAGES) begin
               reply.status = bpa_pkg::STATUS_BAD_COUNT;
            end else begin
               lim   = (limit_setting > MAP_PAGES) ? MAP_PAGES : int'(limit_setting);
               found = -1;
               run   = 0;
               p     = 0;
               while (p < lim && found < 0) begin
                  // A fully used word cannot start a run, so skip it whole.
                  if (run == 0 && p % WB == 0 && p + WB <= lim && &page_words[p / WB]) begin
                     p += WB;
                  end else begin
                     if (page_words[p / WB][p % WB]) begin
                        run = 0;
                     end else begin
                        run++;
                        if (run == int'(count)) found = p + 1 - run;
                     end
                     p++;
                  end
               end
               if (found < 0) begin
                  reply.status = bpa_pkg::STATUS_NO_RUN;
               end else begin
                  mark_pages(found, int'(count), 1'b1);
                  reply.page = bpa_pkg::PAGE_W'(found);
               end
            end
         end
         bpa_pkg::CMD_FREE:    mark_pages(int'(first), int'(count), 1'b0);
         bpa_pkg::CMD_RESERVE: mark_pages(int'(first), int'(count), 1'b1);
         default: ;
      endcase
      return reply;
   endfunction

   task automatic send_request(input logic [bpa_pkg::CMD_W-1:0] cmd, input int first,
                               input int count, output page_reply_type reply);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, bpa_pkg::COUNT_W'(count), bpa_pkg::START_W'(first)};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      reply = apply_page_request(cmd, bpa_pkg::START_W'(first), bpa_pkg::COUNT_W'(count));
      replies_due.push_back(reply);
      items_sent++;
      if (cmd == bpa_pkg::CMD_ALLOC && reply.status == bpa_pkg::STATUS_OK) grants_made++;
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // Callers drain first, so csr_wen is never lowered and raised in one step.
   task automatic write_search_limit(input logic [bpa_pkg::LIMIT_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      limit_setting = value;
      limits_written++;
   endtask

   function automatic void report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
   endfunction

   // Response side: random stalls and the check of every transfer.
   always @(posedge clock) begin
      page_reply_type want;
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("unexpected reply status %0d page %0d",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = replies_due.pop_front();
            replies_checked++;
            if (rsp_tuser !== want.status || rsp_tdata !== want.page) begin
               report_mismatch($sformatf("expected status %0d page %0d, got status %0d page %0d",
                                         want.status, want.page, rsp_tuser, rsp_tdata));
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   task automatic test_reset_map_used();
      page_reply_type reply;
      send_request(bpa_pkg::CMD_ALLOC, 0, 1, reply);
      send_request(bpa_pkg::CMD_ALLOC, 65535, 65536, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 0, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 131071, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 65537, reply);
   endtask

   task automatic test_whole_map_runs();
      page_reply_type reply;
      send_request(bpa_pkg::CMD_FREE, 0, 65536, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 65536, reply);
      // The run starts at the last page and reaches far past the map end.
      send_request(bpa_pkg::CMD_FREE, 65535, 131071, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 1, reply);
      send_request(bpa_pkg::CMD_RESERVE, 0, 0, reply);
      send_request(bpa_pkg::CMD_FREE, 0, 0, reply);
      send_request(CMD_UNUSED, 65535, 131071, reply);
      send_request(bpa_pkg::CMD_FREE, 100, 50, reply);
      send_request(bpa_pkg::CMD_RESERVE, 110, 5, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 10, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 10, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 30, reply);
   endtask

   task automatic test_search_limits();
      page_reply_type reply;
      drain_replies();
      write_search_limit(17'd0);
      send_request(bpa_pkg::CMD_ALLOC, 0, 1, reply);
      drain_replies();
      write_search_limit(17'd1);
      send_request(bpa_pkg::CMD_FREE, 0, 1, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 1, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 1, reply);
      drain_replies();
      write_search_limit(17'd64);
      // Only four free pages lie below the limit, so a run of eight must not cross it.
      send_request(bpa_pkg::CMD_FREE, 60, 11, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 8, reply);
      send_request(bpa_pkg::CMD_ALLOC, 0, 4, reply);
      drain_replies();
      write_search_limit(17'h1FFFF);
      send_request(bpa_pkg::CMD_ALLOC, 0, 7, reply);
   endtask

   function automatic int pick_run_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(16, 1);
      if (r < 95) return $urandom_range(256, 17);
      return $urandom_range(4096, 257);
   endfunction

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int limit, input int span, input int n);
      page_reply_type            reply;
      page_run_type              run;
      logic [bpa_pkg::CMD_W-1:0] cmd;
      int                        r;
      int                        k;
      int                        first;
      int                        count;
      drain_replies();
      write_search_limit(bpa_pkg::LIMIT_W'(limit));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      granted_runs.delete();
      repeat (n) begin
         cmd   = bpa_pkg::CMD_ALLOC;
         first = $urandom_range(span - 1);
         count = pick_run_length();
         r     = $urandom_range(99);
         if (r < 45) begin
            cmd = bpa_pkg::CMD_ALLOC;
         end else if (r < 75) begin
            cmd = bpa_pkg::CMD_FREE;
            // Once runs have been granted, half of these frees give back one of them.
            if (granted_runs.size() != 0 && $urandom_range(1) == 1) begin
               k     = $urandom_range(granted_runs.size() - 1);
               first = granted_runs[k].first;
               count = granted_runs[k].count;
               granted_runs.delete(k);
            end
         end else if (r < 92) begin
            cmd = bpa_pkg::CMD_RESERVE;
         end else begin
            first = $urandom_range(65535);
            case ($urandom_range(3))
               0: count = 0;
               1: count = $urandom_range(131071, 65537);
               2: begin
                  cmd   = CMD_UNUSED;
                  count = $urandom_range(131071);
               end
               default: begin
                  cmd   = ($urandom_range(1) == 1) ? bpa_pkg::CMD_FREE : bpa_pkg::CMD_RESERVE;
                  count = $urandom_range(131071);
               end
            endcase
         end
         if (cmd != bpa_pkg::CMD_ALLOC && $urandom_range(9) == 0) first = $urandom_range(65535);
         send_request(cmd, first, count, reply);
         if (cmd == bpa_pkg::CMD_ALLOC && reply.status == bpa_pkg::STATUS_OK) begin
            run.first = int'(reply.page);
            run.count = count;
            granted_runs.push_back(run);
         end
      end
   endtask

   task automatic finish_run();
      drain_replies();
      repeat (100) @(posedge clock);
      $display("Covered %0d requests with %0d granted allocations under %0d limit settings",
               items_sent, grants_made, limits_written);
      $display("and four idle profiles; %0d replies checked, %0d mismatches.",
               replies_checked, mismatches);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   endtask

   initial begin
      foreach (page_words[i]) page_words[i] = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_map_used();
      test_whole_map_runs();
      test_search_limits();
      test_random_traffic(0, 0, 4096, 4096, 145);
      test_random_traffic(64, 0, 65536, 8192, 145);
      test_random_traffic(0, 64, 1000, 1000, 145);
      test_random_traffic(11, 11, 131071, 16384, 145);
      finish_run();
   end

endmodule
